### rtl/srau_pkg.sv
// shared types and constants of the stack register alu
package srau_pkg;

  // slots at and below the stack top that instructions may address
  localparam int unsigned RegWindow = 8;

  typedef enum logic [4:0] {
    OP_PUSH   = 5'd0,
    OP_DROP   = 5'd1,
    OP_GET    = 5'd2,
    OP_SET    = 5'd3,
    OP_MOV    = 5'd4,
    OP_SWAP   = 5'd5,
    OP_ADDIMM = 5'd6,
    OP_ADD    = 5'd7,
    OP_SUB    = 5'd8,
    OP_MUL    = 5'd9,
    OP_DIVMOD = 5'd10,
    OP_AND    = 5'd11,
    OP_OR     = 5'd12,
    OP_XOR    = 5'd13,
    OP_SHL    = 5'd14,
    OP_SHR    = 5'd15,
    OP_RPUSH  = 5'd16,
    OP_RSET   = 5'd17,
    OP_RGET   = 5'd18,
    OP_RDROP  = 5'd19
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDX,
    S_RDY,
    S_EXEC,
    S_ITER,
    S_WR1,
    S_WR2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clr;
    logic capture;
    logic rd_second;
    logic ld_x;
    logic exec;
    logic md_start;
    logic md_take;
    logic wr1;
    logic wr2;
    logic load_out;
  } srau_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic bad;
    logic div_zero;
    logic need_md;
    logic need_wr;
    logic need_wr2;
    logic md_done;
    logic out_full;
  } srau_sts_t;

endpackage

### rtl/stack_register_alu_unit.sv
// top level of the stack register alu: controller plus datapath
//
// a data stack whose top eight slots act as registers, plus a return stack.
// after reset the block sweeps both stores to zero, one entry per cycle;
// in_ready_o stays low during the sweep. words are then handled one at a
// time: accept, two registered store reads, an execute step, up to two
// write-backs (swap and divmod write two slots) and a load of the output
// register. a rejected word goes from the first store read straight to the
// output load, a divide by zero from execute. mul and divmod pass through
// the shared bit-serial multiply/divide unit between execute and
// write-back. WORD_BITS is to be a power of two; the block does not enforce
// it. shift amounts take the low bits of the shift operand. the output
// register holds a finished word until it is taken, and the next word may
// be accepted meanwhile. an error result (status 1 or 2) changes no state
// and reads zero.
module stack_register_alu_unit #(
  parameter int unsigned DATA_DEPTH   = 64,
  parameter int unsigned RETURN_DEPTH = 32,
  parameter int unsigned WORD_BITS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // instruction channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         operation_i,
  input  logic [2:0]         reg_a_i,
  input  logic [2:0]         reg_b_i,
  input  logic [2:0]         reg_c_i,
  input  logic [2:0]         reg_d_i,
  input  logic signed [31:0] value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_data_o,
  output logic [1:0]         status_o
);
  import srau_pkg::*;

  // command and status between sequencer and datapath
  srau_cmd_t cmd;
  srau_sts_t sts;

  srau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  srau_dp #(
    .DATA_DEPTH  (DATA_DEPTH),
    .RETURN_DEPTH(RETURN_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .operation_i(operation_i),
    .reg_a_i    (reg_a_i),
    .reg_b_i    (reg_b_i),
    .reg_c_i    (reg_c_i),
    .reg_d_i    (reg_d_i),
    .value_i    (value_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .read_data_o(read_data_o),
    .status_o   (status_o)
  );

endmodule

### rtl/srau_md.sv
// iterative shift-add multiplier and restoring divider, one bit per cycle
module srau_md #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 div_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] lo_o,
  output logic [WORD_BITS-1:0] rem_o
);
  import srau_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_BITS);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic                 div_q;
  logic [WORD_BITS-1:0] acc_q;
  logic [WORD_BITS-1:0] sh_q;
  logic [WORD_BITS-1:0] opd_q;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   rem_sub;

  assign rem_sh  = {acc_q, sh_q[WORD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, opd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(WORD_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      acc_q <= '0;
      sh_q  <= a_i;
      opd_q <= b_i;
    end else if (busy_q) begin
      if (div_q) begin
        // restoring step: trial subtract of the divisor
        if (rem_sh >= {1'b0, opd_q}) begin
          acc_q <= rem_sub[WORD_BITS-1:0];
          sh_q  <= {sh_q[WORD_BITS-2:0], 1'b1};
        end else begin
          acc_q <= rem_sh[WORD_BITS-1:0];
          sh_q  <= {sh_q[WORD_BITS-2:0], 1'b0};
        end
      end else begin
        if (sh_q[0]) begin
          acc_q <= acc_q + opd_q;
        end
        opd_q <= {opd_q[WORD_BITS-2:0], 1'b0};
        sh_q  <= {1'b0, sh_q[WORD_BITS-1:1]};
      end
    end
  end

  assign done_o = done_q;
  assign lo_o   = div_q ? sh_q : acc_q;
  assign rem_o  = acc_q;

endmodule

### rtl/srau_dp.sv
// datapath: stores, counts, operand registers, alu and result register
module srau_dp #(
  parameter int unsigned DATA_DEPTH   = 64,
  parameter int unsigned RETURN_DEPTH = 32,
  parameter int unsigned WORD_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srau_pkg::srau_cmd_t cmd_i,
  output srau_pkg::srau_sts_t sts_o,
  input  logic [4:0]          operation_i,
  input  logic [2:0]          reg_a_i,
  input  logic [2:0]          reg_b_i,
  input  logic [2:0]          reg_c_i,
  input  logic [2:0]          reg_d_i,
  input  logic signed [31:0]  value_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  read_data_o,
  output logic [1:0]          status_o
);
  import srau_pkg::*;

  localparam int unsigned DataAw = $clog2(DATA_DEPTH);
  localparam int unsigned DataCw = $clog2(DATA_DEPTH + 1);
  localparam int unsigned RetAw  = $clog2(RETURN_DEPTH);
  localparam int unsigned RetCw  = $clog2(RETURN_DEPTH + 1);
  localparam int unsigned ClrLen = (DATA_DEPTH > RETURN_DEPTH) ? DATA_DEPTH : RETURN_DEPTH;
  localparam int unsigned ClrW   = $clog2(ClrLen);
  localparam int unsigned ShW    = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] data_mem [DATA_DEPTH];
  logic [WORD_BITS-1:0] ret_mem  [RETURN_DEPTH];

  logic [DataCw-1:0]    dcnt_q;
  logic [RetCw-1:0]     rcnt_q;
  logic [ClrW-1:0]      clr_q;
  logic                 out_valid_q;

  op_e                  op_q;
  logic [2:0]           a_q, b_q, c_q, d_q;
  logic [WORD_BITS-1:0] imm_q;
  logic [WORD_BITS-1:0] x_q, mem_q, ret_q, res1_q, res2_q, rdat_q;
  status_e              st_q;
  logic                 nn_q, dn_q;
  logic signed [31:0]   out_data_q;
  status_e              out_st_q;

  op_e                  op_in;
  logic                 bad_in;
  logic [2:0]           src1, src2, rd_idx;
  logic [RetAw-1:0]     rtop;
  logic                 clr_data, clr_ret;

  logic                 md_div;
  logic [WORD_BITS-1:0] md_a, md_b, md_lo, md_rem;
  logic                 md_done;
  logic [ShW-1:0]       sh_amt;

  function automatic logic slot_ok(input logic [2:0] n, input logic [DataCw-1:0] cnt);
    return (32'(n) < RegWindow) && (DataCw'(n) < cnt);
  endfunction

  function automatic logic [DataAw-1:0] slot_pos(input logic [2:0] n,
                                                 input logic [DataCw-1:0] cnt);
    logic [DataCw-1:0] p;
    p = cnt - DataCw'(1) - DataCw'(n);
    return p[DataAw-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + WORD_BITS'(1)) : v;
  endfunction

  // legality check of the incoming word
  always_comb begin
    op_in = op_e'(operation_i);
    unique case (op_in) inside
      OP_PUSH:                      bad_in = (dcnt_q == DataCw'(DATA_DEPTH));
      OP_DROP:                      bad_in = (dcnt_q == '0);
      OP_GET, OP_SET, OP_ADDIMM:    bad_in = !slot_ok(reg_a_i, dcnt_q);
      OP_MOV, OP_SWAP:              bad_in = !slot_ok(reg_a_i, dcnt_q) ||
                                             !slot_ok(reg_b_i, dcnt_q);
      OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
                                    bad_in = !slot_ok(reg_a_i, dcnt_q) ||
                                             !slot_ok(reg_b_i, dcnt_q) ||
                                             !slot_ok(reg_c_i, dcnt_q);
      OP_DIVMOD:                    bad_in = !slot_ok(reg_a_i, dcnt_q) ||
                                             !slot_ok(reg_b_i, dcnt_q) ||
                                             !slot_ok(reg_c_i, dcnt_q) ||
                                             !slot_ok(reg_d_i, dcnt_q);
      OP_RPUSH:                     bad_in = (rcnt_q == RetCw'(RETURN_DEPTH));
      OP_RSET, OP_RGET, OP_RDROP:   bad_in = (rcnt_q == '0);
      default:                      bad_in = 1'b1;
    endcase
  end

  // operand slot selection
  always_comb begin
    unique case (op_q) inside
      OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
                 src1 = b_q;
      OP_DIVMOD: src1 = c_q;
      default:   src1 = a_q;
    endcase
    unique case (op_q) inside
      OP_SWAP:   src2 = b_q;
      OP_DIVMOD: src2 = d_q;
      default:   src2 = c_q;
    endcase
  end

  assign rd_idx   = cmd_i.rd_second ? src2 : src1;
  assign rtop     = RetAw'(rcnt_q - RetCw'(1));
  assign clr_data = cmd_i.clr && ({1'b0, clr_q} < (ClrW + 1)'(DATA_DEPTH));
  assign clr_ret  = cmd_i.clr && ({1'b0, clr_q} < (ClrW + 1)'(RETURN_DEPTH));

  always_comb begin
    unique case (op_q) inside
      OP_DIVMOD: begin
        md_div = 1'b1;
        md_a   = mag(x_q);
        md_b   = mag(mem_q);
      end
      default: begin
        md_div = 1'b0;
        md_a   = x_q;
        md_b   = mem_q;
      end
    endcase
  end

  // shift amount: low bits of the source slot, modulo the word width
  assign sh_amt = mem_q[ShW-1:0];

  srau_md #(
    .WORD_BITS(WORD_BITS)
  ) u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.md_start),
    .div_i  (md_div),
    .a_i    (md_a),
    .b_i    (md_b),
    .done_o (md_done),
    .lo_o   (md_lo),
    .rem_o  (md_rem)
  );

  // data store
  always_ff @(posedge clk_i) begin
    if (clr_data) begin
      data_mem[clr_q[DataAw-1:0]] <= '0;
    end else if (cmd_i.wr1) begin
      data_mem[slot_pos(a_q, dcnt_q)] <= res1_q;
    end else if (cmd_i.wr2) begin
      data_mem[slot_pos(b_q, dcnt_q)] <= res2_q;
    end
    mem_q <= data_mem[slot_pos(rd_idx, dcnt_q)];
  end

  // return store
  always_ff @(posedge clk_i) begin
    if (clr_ret) begin
      ret_mem[clr_q[RetAw-1:0]] <= '0;
    end else if (cmd_i.exec && op_q == OP_RSET) begin
      ret_mem[rtop] <= imm_q;
    end
    ret_q <= ret_mem[rtop];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q      <= '0;
      rcnt_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr && clr_q != ClrW'(ClrLen - 1)) begin
        clr_q <= clr_q + ClrW'(1);
      end
      if (cmd_i.exec) begin
        unique case (op_q) inside
          OP_PUSH:  dcnt_q <= dcnt_q + DataCw'(1);
          OP_DROP:  dcnt_q <= dcnt_q - DataCw'(1);
          OP_RPUSH: rcnt_q <= rcnt_q + RetCw'(1);
          OP_RDROP: rcnt_q <= rcnt_q - RetCw'(1);
          default:  ;
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_in;
      a_q    <= reg_a_i;
      b_q    <= reg_b_i;
      c_q    <= reg_c_i;
      d_q    <= reg_d_i;
      imm_q  <= WORD_BITS'(value_i);
      st_q   <= bad_in ? ST_BAD : ST_OK;
      rdat_q <= '0;
    end
    if (cmd_i.ld_x) begin
      x_q <= mem_q;
    end
    if (cmd_i.exec) begin
      nn_q <= x_q[WORD_BITS-1];
      dn_q <= mem_q[WORD_BITS-1];
      unique case (op_q) inside
        OP_GET:    rdat_q <= x_q;
        OP_RGET:   rdat_q <= ret_q;
        OP_SET:    res1_q <= imm_q;
        OP_MOV:    res1_q <= x_q;
        OP_SWAP: begin
          res1_q <= mem_q;
          res2_q <= x_q;
        end
        OP_ADDIMM: res1_q <= x_q + imm_q;
        OP_ADD:    res1_q <= x_q + mem_q;
        OP_SUB:    res1_q <= x_q - mem_q;
        OP_AND:    res1_q <= x_q & mem_q;
        OP_OR:     res1_q <= x_q | mem_q;
        OP_XOR:    res1_q <= x_q ^ mem_q;
        OP_SHL:    res1_q <= x_q << sh_amt;
        OP_SHR:    res1_q <= WORD_BITS'($signed(x_q) >>> sh_amt);
        OP_DIVMOD: begin
          if (mem_q == '0) begin
            st_q <= ST_DIVZ;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.md_take) begin
      unique case (op_q) inside
        OP_MUL:    res1_q <= md_lo;
        OP_DIVMOD: begin
          res1_q <= (nn_q ^ dn_q) ? (~md_lo + WORD_BITS'(1)) : md_lo;
          res2_q <= nn_q ? (~md_rem + WORD_BITS'(1)) : md_rem;
        end
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      out_data_q <= 32'($signed(rdat_q));
      out_st_q   <= st_q;
    end
  end

  always_comb begin
    sts_o.clr_done = (clr_q == ClrW'(ClrLen - 1));
    sts_o.bad      = (st_q == ST_BAD);
    sts_o.div_zero = (op_q == OP_DIVMOD) && (mem_q == '0);
    sts_o.md_done  = md_done;
    sts_o.out_full = out_valid_q && !out_ready_i;
    unique case (op_q) inside
      OP_MUL, OP_DIVMOD: sts_o.need_md = 1'b1;
      default:           sts_o.need_md = 1'b0;
    endcase
    unique case (op_q) inside
      OP_SET, OP_MOV, OP_SWAP, OP_ADDIMM, OP_ADD, OP_SUB, OP_MUL, OP_DIVMOD,
      OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
               sts_o.need_wr = 1'b1;
      default: sts_o.need_wr = 1'b0;
    endcase
    unique case (op_q) inside
      OP_SWAP, OP_DIVMOD: sts_o.need_wr2 = 1'b1;
      default:            sts_o.need_wr2 = 1'b0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = 2'(out_st_q);

endmodule

### rtl/srau_ctrl.sv
// controller state machine that sequences one instruction at a time
module srau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srau_pkg::srau_sts_t sts_i,
  output srau_pkg::srau_cmd_t cmd_o
);
  import srau_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clr_done) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_RDX;
      S_RDX:   state_d = sts_i.bad ? S_DONE : S_RDY;
      S_RDY:   state_d = S_EXEC;
      S_EXEC: begin
        if (sts_i.div_zero) begin
          state_d = S_DONE;
        end else if (sts_i.need_md) begin
          state_d = S_ITER;
        end else if (sts_i.need_wr) begin
          state_d = S_WR1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ITER:  if (sts_i.md_done) state_d = S_WR1;
      S_WR1:   state_d = sts_i.need_wr2 ? S_WR2 : S_DONE;
      S_WR2:   state_d = S_DONE;
      S_DONE:  if (!sts_i.out_full) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_RDX: cmd_o.rd_second = 1'b0;
      S_RDY: begin
        cmd_o.rd_second = 1'b1;
        cmd_o.ld_x      = 1'b1;
      end
      S_EXEC: begin
        cmd_o.exec     = 1'b1;
        cmd_o.md_start = sts_i.need_md && !sts_i.div_zero;
      end
      S_ITER:  cmd_o.md_take  = sts_i.md_done;
      S_WR1:   cmd_o.wr1      = 1'b1;
      S_WR2:   cmd_o.wr2      = 1'b1;
      S_DONE:  cmd_o.load_out = !sts_i.out_full;
      default: ;
    endcase
  end

endmodule

### rtl/srau_chk.sv
// port-level checker for the stack register alu, bound to the top level
module srau_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [4:0]         operation_i,
  input logic [2:0]         reg_a_i,
  input logic [2:0]         reg_b_i,
  input logic [2:0]         reg_c_i,
  input logic [2:0]         reg_d_i,
  input logic signed [31:0] value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] read_data_o,
  input logic [1:0]         status_o
);
  import srau_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(status_o))
    else $error("result word changed while stalled");

  // one word in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("word accepted while another is in flight");

  // an error result reads zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_data_o == 32'sd0)
    else $error("error result with nonzero read data");

  // status code 3 is never produced
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_BAD || status_o == ST_DIVZ)
    else $error("undefined status code");

endmodule

bind stack_register_alu_unit srau_chk u_srau_chk (.*);
